// ----- sv/tfld_pkg.sv -----
// Shared constants and codes for the tagged frame LED driver.
package tfld_pkg;

   localparam int BYTE_W = 8;
   localparam int STATUS_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int COUNT_W = 5;

   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HUMIDITY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DANGER = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SUM = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_HUMIDITY_TAG = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DANGER_TAG = 2'd1;

   localparam logic [BYTE_W-1:0] HUMIDITY_TAG_RESET = 8'h2D;
   localparam logic [BYTE_W-1:0] DANGER_TAG_RESET = 8'h21;

   // value / 10 for any byte value: (value * 205) >> 11
   localparam logic [BYTE_W-1:0] DIV10_MUL = 8'd205;
   localparam int DIV10_SHIFT = 11;

endpackage

// ----- sv/tagged_frame_led_driver_core.sv -----
// Top level: byte frame parser that drives bar graph and danger LED patterns.
//
// Usage: received bytes enter one per request on the req_ channel. Frames are
// tag, high byte, low byte, checksum (8-bit sum of the two data bytes). Every
// accepted byte yields exactly one response on the rsp_ channel carrying the
// current bar and danger LED patterns and a frame status (none or in progress,
// humidity accepted, danger accepted, checksum error).
// The response is valid in the cycle after the request is accepted. One byte
// is accepted per cycle while the response register is free or being emptied;
// the frame state and LED patterns are updated in the same cycle the response
// register loads. When the receiver stalls, the response register holds, and
// req_ready is high only while that register is empty or being emptied.
// The csr_ channel writes the two tag bytes (index 0 humidity, 1 danger) and
// is always ready; other indexes are ignored.
// Reset clears the parser to waiting for a tag, turns all LEDs off, restores
// the default tags and empties the response register.
module tagged_frame_led_driver_core #(
   parameter int BAR_COUNT = 10,
   parameter int DANGER_COUNT = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tfld_pkg::BYTE_W-1:0]       req_byte_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [BAR_COUNT-1:0]              rsp_bar_leds,
   output logic [DANGER_COUNT-1:0]           rsp_danger_leds,
   output logic [tfld_pkg::STATUS_W-1:0]     rsp_frame_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tfld_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tfld_pkg::BYTE_W-1:0]       csr_data
);

   localparam logic [1:0] PH_TAG = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW = 2'd2;
   localparam logic [1:0] PH_SUM = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic kind_ff, kind_in;
   logic [tfld_pkg::BYTE_W-1:0] high_ff, high_in;
   logic [tfld_pkg::BYTE_W-1:0] low_ff, low_in;
   logic [tfld_pkg::BYTE_W-1:0] hum_tag_ff, danger_tag_ff;
   logic [BAR_COUNT-1:0] bar_ff, bar_in;
   logic [DANGER_COUNT-1:0] danger_ff, danger_in;
   logic [tfld_pkg::STATUS_W-1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic [tfld_pkg::BYTE_W-1:0] sum;
   logic [BAR_COUNT-1:0] bar_new;
   logic [DANGER_COUNT-1:0] danger_new;

   tfld_leds #(
      .BAR_COUNT(BAR_COUNT),
      .DANGER_COUNT(DANGER_COUNT)
   ) u_leds (
      .value(low_ff),
      .bar_pattern(bar_new),
      .danger_pattern(danger_new)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign sum = tfld_pkg::BYTE_W'(high_ff + low_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bar_leds = bar_ff;
   assign rsp_danger_leds = danger_ff;
   assign rsp_frame_status = status_ff;

   always_comb begin
      phase_in = phase_ff;
      kind_in = kind_ff;
      high_in = high_ff;
      low_in = low_ff;
      bar_in = bar_ff;
      danger_in = danger_ff;
      status_in = tfld_pkg::STATUS_NONE;
      unique case (phase_ff)
         PH_TAG: begin
            priority if (req_byte_in == hum_tag_ff) begin
               kind_in = 1'b0;
               phase_in = PH_HIGH;
            end else if (req_byte_in == danger_tag_ff) begin
               kind_in = 1'b1;
               phase_in = PH_HIGH;
            end else begin
               phase_in = PH_TAG;
            end
         end
         PH_HIGH: begin
            high_in = req_byte_in;
            phase_in = PH_LOW;
         end
         PH_LOW: begin
            low_in = req_byte_in;
            phase_in = PH_SUM;
         end
         PH_SUM: begin
            if (req_byte_in == sum) begin
               if (!kind_ff) begin
                  bar_in = bar_new;
                  status_in = tfld_pkg::STATUS_HUMIDITY;
               end else begin
                  danger_in = danger_new;
                  status_in = tfld_pkg::STATUS_DANGER;
               end
            end else begin
               status_in = tfld_pkg::STATUS_BAD_SUM;
            end
            phase_in = PH_TAG;
         end
         default: phase_in = PH_TAG;
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         kind_ff <= 1'b0;
         high_ff <= '0;
         low_ff <= '0;
         bar_ff <= '0;
         danger_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            kind_ff <= kind_in;
            high_ff <= high_in;
            low_ff <= low_in;
            bar_ff <= bar_in;
            danger_ff <= danger_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hum_tag_ff <= tfld_pkg::HUMIDITY_TAG_RESET;
         danger_tag_ff <= tfld_pkg::DANGER_TAG_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == tfld_pkg::CSR_HUMIDITY_TAG) begin
            hum_tag_ff <= csr_data;
         end
         if (csr_index == tfld_pkg::CSR_DANGER_TAG) begin
            danger_tag_ff <= csr_data;
         end
      end
   end

endmodule

// ----- sv/tfld_leds.sv -----
// LED decode: bar thermometer of the byte / 10, danger LED i lit when the byte is i.
module tfld_leds #(
   parameter int BAR_COUNT = 10,
   parameter int DANGER_COUNT = 3
) (
   input  logic [tfld_pkg::BYTE_W-1:0] value,
   output logic [BAR_COUNT-1:0]        bar_pattern,
   output logic [DANGER_COUNT-1:0]     danger_pattern
);

   logic [2*tfld_pkg::BYTE_W-1:0] product;
   logic [tfld_pkg::COUNT_W-1:0]  count;

   assign product = (2*tfld_pkg::BYTE_W)'(value) * (2*tfld_pkg::BYTE_W)'(tfld_pkg::DIV10_MUL);
   assign count = product[tfld_pkg::DIV10_SHIFT +: tfld_pkg::COUNT_W];

   for (genvar i = 0; i < BAR_COUNT; i++) begin : g_bar
      assign bar_pattern[i] = (count > tfld_pkg::COUNT_W'(i));
   end

   for (genvar i = 0; i < DANGER_COUNT; i++) begin : g_danger
      assign danger_pattern[i] = (value == tfld_pkg::BYTE_W'(i));
   end

endmodule
